/* sv/tle_pkg.sv */
// Package for the telnet line editor: cell command type, sequence selectors,
// parse modes and the constant echo sequences.
// No dependencies.
`default_nettype none
package tle_pkg;

    localparam int POS_W = 6;

    localparam logic [7:0] CH_IAC  = 8'd255;
    localparam logic [7:0] CH_WILL = 8'd251;
    localparam logic [7:0] CH_DO   = 8'd253;
    localparam logic [7:0] CH_DONT = 8'd254;
    localparam logic [7:0] CH_EC   = 8'd247;
    localparam logic [7:0] CH_EL   = 8'd248;
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_DEL  = 8'd127;
    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_SP   = 8'd32;
    localparam logic [7:0] CH_LBR  = 8'd91;
    localparam logic [7:0] CH_UP   = 8'd65;
    localparam logic [7:0] CH_DOWN = 8'd66;
    localparam logic [7:0] CH_RGT  = 8'd67;
    localparam logic [7:0] CH_LFT  = 8'd68;
    localparam logic [7:0] CH_K    = 8'd75;
    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;

    localparam logic [1:0] OP_ANNOUNCE = 2'd0;
    localparam logic [1:0] OP_NEWLINE  = 2'd1;
    localparam logic [1:0] OP_BYTE     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic CFG_PROMPT_TEXT = 1'b0;
    localparam logic CFG_PROMPT_LEN  = 1'b1;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_ROTATE = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] lim;
        logic [7:0]       data;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        SEQ_ANNOUNCE = 2'd0,
        SEQ_BACK     = 2'd1,
        SEQ_CLEAR    = 2'd2,
        SEQ_CRLF     = 2'd3
    } seq_t;

    typedef enum logic [4:0] {
        PM_NORMAL  = 5'b00001,
        PM_ESC     = 5'b00010,
        PM_BRACKET = 5'b00100,
        PM_IAC     = 5'b01000,
        PM_NEG     = 5'b10000
    } parse_mode_t;

    function automatic logic [3:0] seq_len(seq_t sel);
        logic [3:0] n;
        case (sel)
            SEQ_ANNOUNCE: n = 4'd9;
            SEQ_BACK:     n = 4'd7;
            SEQ_CLEAR:    n = 4'd4;
            SEQ_CRLF:     n = 4'd2;
            default:      n = 4'd2;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(seq_t sel, logic [3:0] idx);
        logic [7:0] b;
        b = 8'd0;
        case (sel)
            SEQ_ANNOUNCE:
                case (idx)
                    4'd0, 4'd3, 4'd6: b = CH_IAC;
                    4'd1, 4'd4:       b = CH_WILL;
                    4'd2:             b = OPT_ECHO;
                    4'd7:             b = CH_DO;
                    default:          b = OPT_SGA;
                endcase
            SEQ_BACK:
                case (idx)
                    4'd0, 4'd4: b = CH_ESC;
                    4'd1, 4'd5: b = CH_LBR;
                    4'd3:       b = CH_SP;
                    default:    b = CH_LFT;
                endcase
            SEQ_CLEAR:
                case (idx)
                    4'd0:    b = CH_CR;
                    4'd1:    b = CH_ESC;
                    4'd2:    b = CH_LBR;
                    default: b = CH_K;
                endcase
            default:
                b = (idx == 4'd0) ? CH_CR : CH_LF;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

/* sv/telnet_line_editor.sv */
// Top level of the telnet line editor: parser, output sequencer and the
// rotating chain of byte cells that holds the line. Depends on tle_pkg, tle_cell.
//
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    opcode, rx_byte
// result    out        out_valid / out_ready  out_byte, destination, line_end, last
// config    in         cfg_we                 cfg_index, cfg_data
//
// One request at a time: a new request is taken only in idle, once the bytes
// of the last one are issued and the ring is back home. A request that reads
// the store also turns the cell ring once, one cell per cycle unless an
// output stall holds it. Output stalls hold the sequencer. Reset clears
// cursor, end and parse state.
`default_nettype none
module telnet_line_editor #(
    parameter int LINE_DEPTH = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [1:0]   opcode,
    input  wire [7:0]   rx_byte,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [7:0]  out_byte,
    output logic        destination,
    output logic        line_end,
    output logic        last,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire [63:0]  cfg_data
);
    import tle_pkg::*;

    localparam logic [POS_W-1:0] DEPTH = POS_W'(LINE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CONST   = 7'b0000010,
        S_STORE   = 7'b0000100,
        S_TERM    = 7'b0001000,
        S_PROMPT  = 7'b0010000,
        S_SINGLE  = 7'b0100000,
        S_RESTORE = 7'b1000000
    } eng_state_t;

    typedef struct packed {
        logic c;
        logic s;
        logic t;
        logic p;
        logic g;
    } seg_flags_t;

    function automatic eng_state_t pick(seg_flags_t f);
        eng_state_t s;
        if (f.c)      s = S_CONST;
        else if (f.s) s = S_STORE;
        else if (f.t) s = S_TERM;
        else if (f.p) s = S_PROMPT;
        else if (f.g) s = S_SINGLE;
        else          s = S_RESTORE;
        return s;
    endfunction

    logic [63:0]      prompt_reg;
    logic [3:0]       plen_reg;
    eng_state_t       state_reg, state_next;
    parse_mode_t      mode_reg, mode_next;
    logic [POS_W-1:0] cursor_reg, cursor_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [POS_W-1:0] rot_reg, rot_next;
    seg_flags_t       flags_reg, flags_next, flags_done;
    seq_t             sel_reg, sel_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [POS_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic             dest_reg, dest_next;
    logic [7:0]       g_reg, g_next;
    logic             ov_reg, ov_next;
    logic [7:0]       ob_reg, ob_next;
    logic             od_reg, od_next, ole_reg, ole_next, ol_reg, ol_next;

    cell_cmd_t        cmd;
    logic [7:0]       cell_data [LINE_DEPTH];
    logic [3:0]       plen_eff;
    logic             slot;
    logic             accept;

    assign plen_eff = (plen_reg > 4'd8) ? 4'd8 : plen_reg;
    assign slot     = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    genvar gi;
    generate
        for (gi = 0; gi < LINE_DEPTH; gi++)
        begin : g_cell
            tle_cell #(.INDEX(gi)) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .left_data  ((gi == 0) ? 8'd0 : cell_data[(gi + LINE_DEPTH - 1) % LINE_DEPTH]),
                .right_data (cell_data[(gi + 1) % LINE_DEPTH]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        cursor_next = cursor_reg;
        end_next    = end_reg;
        rot_next    = rot_reg;
        flags_next  = flags_reg;
        flags_done  = flags_reg;
        sel_next    = sel_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        dest_next   = dest_reg;
        g_next      = g_reg;
        ov_next     = ov_reg && !out_ready;
        ob_next     = ob_reg;
        od_next     = od_reg;
        ole_next    = ole_reg;
        ol_next     = ol_reg;
        cmd         = '{kind: CMD_HOLD, pos: '0, lim: '0, data: 8'd0};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    flags_next = '0;
                    cnt_next   = 4'd0;
                    case (opcode)
                        OP_ANNOUNCE:
                        begin
                            flags_next.c = 1'b1;
                            sel_next     = SEQ_ANNOUNCE;
                        end
                        OP_NEWLINE:
                        begin
                            end_next     = cursor_reg;
                            cursor_next  = '0;
                            mode_next    = PM_NORMAL;
                            flags_next.p = (plen_eff != 4'd0);
                        end
                        OP_BYTE:
                        begin
                            mode_next = PM_NORMAL;
                            case (mode_reg)
                                PM_ESC:
                                    if (rx_byte == CH_LBR)
                                        mode_next = PM_BRACKET;
                                PM_BRACKET:
                                begin
                                    if (rx_byte == CH_UP)
                                    begin
                                        cursor_next  = '0;
                                        flags_next.c = 1'b1;
                                        sel_next     = SEQ_CLEAR;
                                        flags_next.p = (plen_eff != 4'd0);
                                    end
                                    else if (rx_byte == CH_DOWN || rx_byte == CH_RGT)
                                    begin
                                        if (cursor_reg < end_reg)
                                        begin
                                            flags_next.s = 1'b1;
                                            lo_next      = cursor_reg;
                                            dest_next    = 1'b0;
                                            hi_next      = (rx_byte == CH_DOWN) ?
                                                           end_reg : cursor_reg + 1'b1;
                                            cursor_next  = hi_next;
                                        end
                                    end
                                    else if (rx_byte == CH_LFT)
                                    begin
                                        if (cursor_reg != '0)
                                        begin
                                            cursor_next  = cursor_reg - 1'b1;
                                            flags_next.c = 1'b1;
                                            sel_next     = SEQ_BACK;
                                        end
                                    end
                                end
                                PM_IAC:
                                begin
                                    if (rx_byte == CH_EC)
                                    begin
                                        if (cursor_reg != '0)
                                        begin
                                            cursor_next  = cursor_reg - 1'b1;
                                            flags_next.c = 1'b1;
                                            sel_next     = SEQ_BACK;
                                        end
                                    end
                                    else if (rx_byte == CH_EL)
                                    begin
                                        cursor_next  = '0;
                                        flags_next.c = 1'b1;
                                        sel_next     = SEQ_CLEAR;
                                        flags_next.p = (plen_eff != 4'd0);
                                    end
                                    else if (rx_byte >= CH_WILL && rx_byte <= CH_DONT)
                                        mode_next = PM_NEG;
                                end
                                PM_NEG:
                                    mode_next = PM_NORMAL;
                                default:
                                begin
                                    if (rx_byte == CH_CR)
                                    begin
                                        flags_next.c = 1'b1;
                                        sel_next     = SEQ_CRLF;
                                        flags_next.s = (cursor_reg != '0);
                                        lo_next      = '0;
                                        hi_next      = cursor_reg;
                                        dest_next    = 1'b1;
                                        flags_next.t = 1'b1;
                                    end
                                    else if (rx_byte == CH_BS || rx_byte == CH_DEL)
                                    begin
                                        if (cursor_reg != '0 && end_reg != '0)
                                        begin
                                            cursor_next  = cursor_reg - 1'b1;
                                            end_next     = end_reg - 1'b1;
                                            cmd.kind     = CMD_DELETE;
                                            cmd.pos      = cursor_next;
                                            cmd.lim      = end_next;
                                            flags_next.c = 1'b1;
                                            sel_next     = SEQ_BACK;
                                        end
                                    end
                                    else if (rx_byte == CH_ESC)
                                        mode_next = PM_ESC;
                                    else if (rx_byte == CH_IAC)
                                        mode_next = PM_IAC;
                                    else if (rx_byte >= CH_SP)
                                    begin
                                        if (end_reg < DEPTH)
                                        begin
                                            cmd.kind     = CMD_INSERT;
                                            cmd.pos      = cursor_reg;
                                            cmd.lim      = end_reg;
                                            cmd.data     = rx_byte;
                                            cursor_next  = cursor_reg + 1'b1;
                                            end_next     = end_reg + 1'b1;
                                            flags_next.g = 1'b1;
                                            g_next       = rx_byte;
                                        end
                                    end
                                end
                            endcase
                        end
                        default: ;
                    endcase
                    state_next = pick(flags_next);
                end
            end
            S_CONST:
            begin
                if (slot)
                begin
                    flags_done.c = 1'b0;
                    ov_next  = 1'b1;
                    ob_next  = seq_byte(sel_reg, cnt_reg);
                    od_next  = 1'b0;
                    ole_next = 1'b0;
                    ol_next  = 1'b0;
                    if (cnt_reg == seq_len(sel_reg) - 4'd1)
                    begin
                        cnt_next   = 4'd0;
                        flags_next = flags_done;
                        state_next = pick(flags_done);
                        ol_next    = (pick(flags_done) == S_RESTORE);
                    end
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
            end
            S_STORE:
            begin
                if (rot_reg < lo_reg)
                begin
                    cmd.kind = CMD_ROTATE;
                    rot_next = rot_reg + 1'b1;
                end
                else if (slot)
                begin
                    cmd.kind     = CMD_ROTATE;
                    rot_next     = rot_reg + 1'b1;
                    flags_done.s = 1'b0;
                    ov_next  = 1'b1;
                    ob_next  = cell_data[0];
                    od_next  = dest_reg;
                    ole_next = 1'b0;
                    ol_next  = 1'b0;
                    if (rot_reg == hi_reg - 1'b1)
                    begin
                        flags_next = flags_done;
                        state_next = pick(flags_done);
                        ol_next    = (pick(flags_done) == S_RESTORE);
                    end
                end
            end
            S_TERM:
            begin
                if (slot)
                begin
                    flags_done.t = 1'b0;
                    flags_next   = flags_done;
                    state_next   = pick(flags_done);
                    ov_next  = 1'b1;
                    ob_next  = 8'd0;
                    od_next  = 1'b1;
                    ole_next = 1'b1;
                    ol_next  = (pick(flags_done) == S_RESTORE);
                end
            end
            S_PROMPT:
            begin
                if (slot)
                begin
                    flags_done.p = 1'b0;
                    ov_next  = 1'b1;
                    ob_next  = prompt_reg[cnt_reg[2:0]*8 +: 8];
                    od_next  = 1'b0;
                    ole_next = 1'b0;
                    ol_next  = 1'b0;
                    if (cnt_reg == plen_eff - 4'd1)
                    begin
                        cnt_next   = 4'd0;
                        flags_next = flags_done;
                        state_next = pick(flags_done);
                        ol_next    = (pick(flags_done) == S_RESTORE);
                    end
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
            end
            S_SINGLE:
            begin
                if (slot)
                begin
                    flags_done.g = 1'b0;
                    flags_next   = flags_done;
                    state_next   = pick(flags_done);
                    ov_next  = 1'b1;
                    ob_next  = g_reg;
                    od_next  = 1'b0;
                    ole_next = 1'b0;
                    ol_next  = (pick(flags_done) == S_RESTORE);
                end
            end
            S_RESTORE:
            begin
                // A full turn of the ring leaves every cell where it started.
                if (rot_reg == '0 || rot_reg == DEPTH)
                begin
                    rot_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.kind = CMD_ROTATE;
                    rot_next = rot_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= PM_NORMAL;
            cursor_reg <= '0;
            end_reg    <= '0;
            rot_reg    <= '0;
            flags_reg  <= '0;
            cnt_reg    <= 4'd0;
            ov_reg     <= 1'b0;
            prompt_reg <= 64'd0;
            plen_reg   <= 4'd0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            cursor_reg <= cursor_next;
            end_reg    <= end_next;
            rot_reg    <= rot_next;
            flags_reg  <= flags_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_PROMPT_TEXT)
                    prompt_reg <= cfg_data;
                else if (cfg_index == CFG_PROMPT_LEN)
                    plen_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        dest_reg <= dest_next;
        g_reg    <= g_next;
        ob_reg   <= ob_next;
        od_reg   <= od_next;
        ole_reg  <= ole_next;
        ol_reg   <= ol_next;
    end

    assign out_valid   = ov_reg;
    assign out_byte    = ob_reg;
    assign destination = od_reg;
    assign line_end    = ole_reg;
    assign last        = ol_reg;

    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> rot_reg == '0)
        else $error("cell ring not at home position while idle");

    a_cursor_end: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= end_reg && end_reg <= DEPTH)
        else $error("cursor or end position out of range");

    a_idle_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESTORE) |-> flags_reg == '0)
        else $error("pending output segments outside the sequencer");

    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ole_reg) |-> ol_reg && od_reg)
        else $error("line terminator not the final consumer result");

endmodule
`default_nettype wire

/* sv/tle_cell.sv */
// One byte cell of the line store chain. It holds, loads, or takes the byte
// of its left or right neighbor as the shared command says.
// Depends on tle_pkg.
`default_nettype none
module tle_cell #(
    parameter int INDEX = 0
) (
    input  wire                 clk,
    input  tle_pkg::cell_cmd_t  cmd,
    input  wire [7:0]           left_data,
    input  wire [7:0]           right_data,
    output logic [7:0]          data
);
    import tle_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.kind)
            CMD_ROTATE: data_next = right_data;
            CMD_INSERT:
            begin
                if (IDX == cmd.pos)
                    data_next = cmd.data;
                else if (IDX > cmd.pos && IDX <= cmd.lim)
                    data_next = left_data;
            end
            CMD_DELETE:
            begin
                if (IDX >= cmd.pos && IDX < cmd.lim)
                    data_next = right_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the telnet line editor: directed and random
// requests, a scoreboard class holding the editor state and expected bytes.
// Depends on tle_pkg and telnet_line_editor.
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
    logic [7:0] ch;
    logic       dest;
    logic       eol;
    logic       fin;
} echo_item_t;

class editor_scoreboard;
    localparam int DEPTH = 32;
    localparam logic [2:0] MD_NORMAL = 3'd0, MD_ESC = 3'd1, MD_BRACKET = 3'd2,
        MD_IAC = 3'd3, MD_NEG = 3'd4;

    logic [63:0] prompt_text;
    logic [3:0]  prompt_len;
    logic [2:0]  mode;
    logic [7:0]  line_mem [DEPTH];
    int          cursor;
    int          fill;
    echo_item_t  pending [$];
    echo_item_t  staged [$];
    int          mismatches;
    int          checked;
    int          lines_delivered;

    function new();
        prompt_text = '0;
        prompt_len = '0;
        mode = MD_NORMAL;
        cursor = 0;
        fill = 0;
        mismatches = 0;
        checked = 0;
        lines_delivered = 0;
        foreach (line_mem[i]) line_mem[i] = '0;
    endfunction

    function void put(logic [7:0] b, logic d, logic e);
        echo_item_t it;
        it.ch = b;
        it.dest = d;
        it.eol = e;
        it.fin = 1'b0;
        staged.push_back(it);
    endfunction

    function void put_prompt();
        int n;
        n = (prompt_len > 8) ? 8 : int'(prompt_len);
        for (int i = 0; i < n; i++) put(prompt_text[8*i +: 8], 1'b0, 1'b0);
    endfunction

    function void put_back();
        put(tle_pkg::CH_ESC, 0, 0); put(tle_pkg::CH_LBR, 0, 0);
        put(tle_pkg::CH_LFT, 0, 0); put(tle_pkg::CH_SP, 0, 0);
        put(tle_pkg::CH_ESC, 0, 0); put(tle_pkg::CH_LBR, 0, 0);
        put(tle_pkg::CH_LFT, 0, 0);
    endfunction

    function void step_back();
        if (cursor > 0)
        begin
            cursor--;
            put_back();
        end
    endfunction

    function void clear_line();
        cursor = 0;
        put(tle_pkg::CH_CR, 0, 0); put(tle_pkg::CH_ESC, 0, 0);
        put(tle_pkg::CH_LBR, 0, 0); put(tle_pkg::CH_K, 0, 0);
        put_prompt();
    endfunction

    function void plain_byte(logic [7:0] b);
        if (b == tle_pkg::CH_CR)
        begin
            put(tle_pkg::CH_CR, 0, 0);
            put(tle_pkg::CH_LF, 0, 0);
            for (int i = 0; i < cursor; i++) put(line_mem[i], 1, 0);
            put(8'd0, 1, 1);
            lines_delivered++;
        end
        else if (b == tle_pkg::CH_BS || b == tle_pkg::CH_DEL)
        begin
            if (cursor > 0 && fill > 0)
            begin
                cursor--;
                fill--;
                for (int i = cursor; i < fill && i + 1 < DEPTH; i++)
                    line_mem[i] = line_mem[i+1];
                put_back();
            end
        end
        else if (b == tle_pkg::CH_ESC)
            mode = MD_ESC;
        else if (b == tle_pkg::CH_IAC)
            mode = MD_IAC;
        else if (b >= tle_pkg::CH_SP)
        begin
            if (fill < DEPTH)
            begin
                for (int i = fill; i > cursor; i--) line_mem[i] = line_mem[i-1];
                line_mem[cursor] = b;
                cursor++;
                fill++;
                put(b, 0, 0);
            end
        end
    endfunction

    function void arrow_key(logic [7:0] b);
        if (b == tle_pkg::CH_UP)
            clear_line();
        else if (b == tle_pkg::CH_DOWN)
        begin
            while (cursor < fill)
            begin
                put(line_mem[cursor], 0, 0);
                cursor++;
            end
        end
        else if (b == tle_pkg::CH_RGT)
        begin
            if (cursor < fill)
            begin
                put(line_mem[cursor], 0, 0);
                cursor++;
            end
        end
        else if (b == tle_pkg::CH_LFT)
            step_back();
    endfunction

    // Notes an accepted request and queues the bytes it must produce.
    function void note_request(logic [1:0] op, logic [7:0] b);
        staged.delete();
        if (op == tle_pkg::OP_ANNOUNCE)
        begin
            put(tle_pkg::CH_IAC, 0, 0); put(tle_pkg::CH_WILL, 0, 0);
            put(tle_pkg::OPT_ECHO, 0, 0); put(tle_pkg::CH_IAC, 0, 0);
            put(tle_pkg::CH_WILL, 0, 0); put(tle_pkg::OPT_SGA, 0, 0);
            put(tle_pkg::CH_IAC, 0, 0); put(tle_pkg::CH_DO, 0, 0);
            put(tle_pkg::OPT_SGA, 0, 0);
        end
        else if (op == tle_pkg::OP_NEWLINE)
        begin
            fill = cursor;
            cursor = 0;
            mode = MD_NORMAL;
            put_prompt();
        end
        else if (op == tle_pkg::OP_BYTE)
        begin
            case (mode)
                MD_ESC:
                    mode = (b == tle_pkg::CH_LBR) ? MD_BRACKET : MD_NORMAL;
                MD_BRACKET:
                begin
                    mode = MD_NORMAL;
                    arrow_key(b);
                end
                MD_IAC:
                begin
                    mode = MD_NORMAL;
                    if (b == tle_pkg::CH_EC)
                        step_back();
                    else if (b == tle_pkg::CH_EL)
                        clear_line();
                    else if (b >= tle_pkg::CH_WILL && b <= tle_pkg::CH_DONT)
                        mode = MD_NEG;
                end
                MD_NEG:
                    mode = MD_NORMAL;
                default:
                    plain_byte(b);
            endcase
        end
        if (staged.size() > 0) staged[staged.size()-1].fin = 1'b1;
        foreach (staged[i]) pending.push_back(staged[i]);
    endfunction

    function void check_result(echo_item_t got);
        echo_item_t exp_item;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: byte %0d dest %0d end %0d last %0d",
                    got.ch, got.dest, got.eol, got.fin);
            return;
        end
        exp_item = pending.pop_front();
        if (got !== exp_item)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected byte %0d dest %0d end %0d last %0d, got %0d %0d %0d %0d",
                    exp_item.ch, exp_item.dest, exp_item.eol, exp_item.fin,
                    got.ch, got.dest, got.eol, got.fin);
        end
    endfunction
endclass

module testbench;
    import tle_pkg::*;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        destination;
    logic        line_end;
    logic        last;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    editor_scoreboard board;
    int cycles;
    int requests_sent;
    int hold_off;
    bit random_stalls;

    telnet_line_editor #(.LINE_DEPTH(DEPTH)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
        .destination(destination), .line_end(line_end), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: checks on accepted bytes and paces out_ready.
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result({out_byte, destination, line_end, last});
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (out_ready && out_valid)
            begin
                wait_n = random_stalls ? $urandom_range(0, 13) : 0;
                if ($urandom_range(0, 3) == 0) wait_n = 0;
                if (wait_n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (wait_n - 1) @(posedge clk);
                end
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Valid stays high after an accept until the next request or an idle
    // point drops it; the block is not ready again in the cycle after an accept.
    task automatic send_request(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = random_stalls ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        rx_byte <= b;
        do @(posedge clk); while (!(in_valid && in_ready));
        board.note_request(op, b);
        requests_sent++;
    endtask

    task automatic typed(input logic [7:0] b);
        send_request(OP_BYTE, b);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (DEPTH + 60) @(posedge clk);
    endtask

    task automatic set_prompt(input logic [63:0] txt, input logic [3:0] n);
        in_valid <= 1'b0;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PROMPT_TEXT;
        cfg_data <= txt;
        @(posedge clk);
        cfg_index <= CFG_PROMPT_LEN;
        cfg_data <= {60'd0, n};
        @(posedge clk);
        cfg_we <= 1'b0;
        board.prompt_text = txt;
        board.prompt_len = n;
    endtask

    // Mostly well-formed edits with random content, plus some noise.
    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            typed(8'($urandom_range(32, 126)));
        else if (pick < 45)
            typed(8'($urandom_range(128, 254)));
        else if (pick < 52)
            typed($urandom_range(0, 1) ? CH_BS : CH_DEL);
        else if (pick < 66)
        begin
            typed(CH_ESC);
            typed(CH_LBR);
            typed(8'($urandom_range(65, 68)));
        end
        else if (pick < 72)
            typed(CH_CR);
        else if (pick < 76)
            send_request(OP_NEWLINE, 8'($urandom));
        else if (pick < 78)
            send_request(OP_ANNOUNCE, 8'($urandom));
        else if (pick < 84)
        begin
            typed(CH_IAC);
            typed(8'($urandom_range(247, 255)));
            if ($urandom_range(0, 1)) typed(8'($urandom));
        end
        else if (pick < 88)
            send_request(OP_RESERVED, 8'($urandom));
        else if (pick < 92)
        begin
            typed(CH_ESC);
            typed(8'($urandom));
        end
        else
            typed(8'($urandom));
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        rx_byte = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        hold_off = 0;
        random_stalls = 0;
        requests_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty prompt, announce, editing, arrows, IAC commands.
        send_request(OP_NEWLINE, 8'h00);
        set_prompt(64'h2020_3e74_656e_6c65, 4'd8);
        send_request(OP_ANNOUNCE, 8'hFF);
        send_request(OP_NEWLINE, 8'h00);
        typed(8'h20); typed(8'h7E); typed(8'hFE); typed(8'h80);
        typed(8'h01); typed(CH_BS);
        typed(CH_ESC); typed(CH_LBR); typed(CH_LFT);
        typed(CH_DEL); typed(8'h61);
        typed(CH_ESC); typed(CH_LBR); typed(CH_RGT);
        typed(CH_IAC); typed(CH_EC);
        typed(CH_ESC); typed(CH_LBR); typed(CH_UP);
        typed(CH_ESC); typed(CH_LBR); typed(CH_DOWN);
        typed(CH_IAC); typed(CH_DO); typed(OPT_SGA);
        typed(CH_IAC); typed(CH_IAC);
        typed(CH_ESC); typed(8'h58); typed(CH_ESC); typed(CH_LBR); typed(CH_K);
        send_request(OP_RESERVED, 8'h55);
        typed(CH_CR);
        typed(CH_IAC); typed(CH_EL);
        wait_drained();

        // Fill the store past its depth, deliver, then recall.
        set_prompt(64'h3e, 4'd1);
        for (int i = 0; i < DEPTH + 3; i++) typed(8'($urandom_range(32, 255)));
        typed(CH_CR);
        send_request(OP_NEWLINE, 8'h00);
        typed(CH_ESC); typed(CH_LBR); typed(CH_DOWN);
        typed(CH_CR);

        // Receiver holds off while the sender keeps offering requests.
        wait_drained();
        hold_off = 200;
        for (int i = 0; i < 6; i++) send_request(OP_ANNOUNCE, 8'h00);
        wait_drained();

        random_stalls = 1;
        set_prompt({$urandom, $urandom}, 4'($urandom_range(0, 15)));
        for (int i = 0; i < 20; i++) random_request();
        wait_drained();
        set_prompt(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        for (int i = 0; i < 20; i++)
        begin
            random_stalls = (i % 20) < 14;
            random_request();
        end
        wait_drained();
        set_prompt({$urandom, $urandom}, 4'($urandom_range(0, 8)));
        for (int i = 0; i < 20; i++) random_request();
        wait_drained();

        $display("covered %0d requests, %0d result bytes, %0d delivered lines",
            requests_sent, board.checked, board.lines_delivered);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
        begin
            $display("%0d mismatches, %0d results missing",
                board.mismatches, board.pending.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* files.f */
sv/tle_pkg.sv
sv/tle_cell.sv
sv/telnet_line_editor.sv
tb/testbench.sv
